@@ hw/rtl/sdg_pkg.sv @@
// ============================================================================
// sdg_pkg
// Shared types and constants of the sidechain ducking gain stage.
// ============================================================================
`default_nettype none

package sdg_pkg;

   localparam int SAMPLE_BITS = 24;
   localparam int COEFF_BITS  = 16;
   localparam int RECIP_BITS  = 24;
   localparam int RECIP_FRAC  = 16;

   // Multiplier operands are one bit wider than a sample so that unsigned
   // Q1.23 levels and signed samples share the same signed multiplier.
   localparam int MUL_BITS  = SAMPLE_BITS + 1;
   localparam int PROD_BITS = 2 * MUL_BITS;

   localparam logic [SAMPLE_BITS-1:0] ONE_Q = SAMPLE_BITS'(1) << (SAMPLE_BITS - 1);

   // Configuration port.
   localparam int CSR_ADDR_BITS = 5;
   localparam int CSR_DATA_BITS = 32;
   localparam int REG_IDX_BITS  = 3;

   localparam logic [REG_IDX_BITS-1:0] REG_ATTACK    = 3'd0;
   localparam logic [REG_IDX_BITS-1:0] REG_RELEASE   = 3'd1;
   localparam logic [REG_IDX_BITS-1:0] REG_THRESHOLD = 3'd2;
   localparam logic [REG_IDX_BITS-1:0] REG_DEPTH     = 3'd3;
   localparam logic [REG_IDX_BITS-1:0] REG_RECIP     = 3'd4;
   localparam logic [REG_IDX_BITS-1:0] REG_SIDECHAIN = 3'd5;

   localparam logic [COEFF_BITS-1:0]  RESET_ATTACK    = 16'd65400;
   localparam logic [COEFF_BITS-1:0]  RESET_RELEASE   = 16'd65529;
   localparam logic [SAMPLE_BITS-1:0] RESET_THRESHOLD = 24'd838861;
   localparam logic [SAMPLE_BITS-1:0] RESET_DEPTH     = 24'd838861;
   localparam logic [RECIP_BITS-1:0]  RESET_RECIP     = 24'd72818;
   localparam logic                   RESET_SIDECHAIN = 1'b1;

   // Queue between the front and the back.
   localparam int QUEUE_DEPTH     = 2;
   localparam int QUEUE_PTR_BITS  = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_BITS  = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] side_left;
      logic signed [SAMPLE_BITS-1:0] side_right;
      logic signed [SAMPLE_BITS-1:0] main_left;
      logic signed [SAMPLE_BITS-1:0] main_right;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] out_left;
      logic signed [SAMPLE_BITS-1:0] out_right;
      logic        [SAMPLE_BITS-1:0] applied_gain;
      logic        [SAMPLE_BITS-1:0] envelope_level;
   } rsp_type;

   // One classified frame as it waits in the queue.
   typedef struct packed {
      logic        [SAMPLE_BITS-1:0] peak;
      logic signed [SAMPLE_BITS-1:0] main_left;
      logic signed [SAMPLE_BITS-1:0] main_right;
   } work_type;

   typedef struct packed {
      logic [COEFF_BITS-1:0]  attack_coeff;
      logic [COEFF_BITS-1:0]  release_coeff;
      logic [SAMPLE_BITS-1:0] threshold_level;
      logic [SAMPLE_BITS-1:0] depth_level;
      logic [RECIP_BITS-1:0]  range_recip;
      logic                   sidechain_on;
   } cfg_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ENV_MUL,
      ST_ENV_UPD,
      ST_EXC_MUL,
      ST_EXC_SET,
      ST_GAIN_MUL,
      ST_GAIN_SET,
      ST_RIGHT_SET,
      ST_LEFT_OUT,
      ST_RIGHT_OUT
   } back_state_type;

endpackage

`default_nettype wire

@@ hw/rtl/sdg_front.sv @@
// ============================================================================
// sdg_front
// Takes frames from the input channel and reduces the sidechain to a peak.
// ============================================================================
`default_nettype none

module sdg_front (
   input  wire logic              req_push,
   output logic                   req_full,
   input  wire sdg_pkg::req_type  req_data,
   input  wire logic              sidechain_on,
   input  wire logic              q_full,
   output logic                   q_push,
   output sdg_pkg::work_type      q_data
);

   logic [sdg_pkg::SAMPLE_BITS-1:0] mag_left;
   logic [sdg_pkg::SAMPLE_BITS-1:0] mag_right;

   // The magnitude of the most negative sample is ONE, which still fits
   // as an unsigned value.
   assign mag_left  = req_data.side_left[sdg_pkg::SAMPLE_BITS-1] ?
                      (~req_data.side_left + 1'b1) : req_data.side_left;
   assign mag_right = req_data.side_right[sdg_pkg::SAMPLE_BITS-1] ?
                      (~req_data.side_right + 1'b1) : req_data.side_right;

   always_comb begin
      q_data.main_left  = req_data.main_left;
      q_data.main_right = req_data.main_right;
      if (!sidechain_on) begin
         q_data.peak = '0;
      end else if (mag_left > mag_right) begin
         q_data.peak = mag_left;
      end else begin
         q_data.peak = mag_right;
      end
   end

   assign req_full = q_full;
   assign q_push   = req_push && !q_full;

endmodule

`default_nettype wire

@@ hw/rtl/sdg_queue.sv @@
// ============================================================================
// sdg_queue
// Short first-in first-out queue of classified frames.
// ============================================================================
`default_nettype none

module sdg_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire sdg_pkg::work_type  push_data,
   input  wire logic               pop,
   output logic                    full,
   output logic                    empty,
   output sdg_pkg::work_type       head
);

   sdg_pkg::work_type                   entries_ff [sdg_pkg::QUEUE_DEPTH];
   logic [sdg_pkg::QUEUE_PTR_BITS-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [sdg_pkg::QUEUE_PTR_BITS-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [sdg_pkg::QUEUE_CNT_BITS-1:0]  count_ff, count_in;
   logic                                do_push;
   logic                                do_pop;

   assign full    = (count_ff == sdg_pkg::QUEUE_CNT_BITS'(sdg_pkg::QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign head    = entries_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == sdg_pkg::QUEUE_PTR_BITS'(sdg_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == sdg_pkg::QUEUE_PTR_BITS'(sdg_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= sdg_pkg::QUEUE_CNT_BITS'(sdg_pkg::QUEUE_DEPTH))
      else $error("queue holds more frames than it has entries");

   assert property (@(posedge clock) disable iff (reset)
      (do_push && !do_pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue count did not follow a lone push");

   assert property (@(posedge clock) disable iff (reset)
      ((count_ff == '0) == (wr_ptr_ff == rd_ptr_ff)) || full)
      else $error("queue pointers disagree with the count");

endmodule

`default_nettype wire

@@ hw/rtl/sdg_back.sv @@
// ============================================================================
// sdg_back
// Envelope follower and gain computer around one shared multiplier, with
// the one-entry result register in front of the output channel.
// ============================================================================
`default_nettype none

module sdg_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire sdg_pkg::cfg_type   cfg,
   input  wire logic               q_empty,
   input  wire sdg_pkg::work_type  q_head,
   output logic                    q_pop,
   output logic                    rsp_empty,
   input  wire logic               rsp_pop,
   output sdg_pkg::rsp_type        rsp_data
);

   localparam int SB = sdg_pkg::SAMPLE_BITS;
   localparam int MB = sdg_pkg::MUL_BITS;
   localparam int PB = sdg_pkg::PROD_BITS;
   localparam int EXC_BITS = PB - sdg_pkg::RECIP_FRAC;

   sdg_pkg::back_state_type  state_ff, state_in;
   sdg_pkg::work_type        work_ff, work_in;
   logic [SB-1:0]            env_ff, env_in;
   logic [SB-1:0]            gain_ff, gain_in;
   logic                     above_ff, above_in;
   logic signed [MB-1:0]     a_ff, a_in;
   logic signed [MB-1:0]     b_ff, b_in;
   logic signed [PB-1:0]     prod_ff, prod_in;
   logic signed [SB-1:0]     left_ff, left_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   sdg_pkg::rsp_type         rsp_data_ff, rsp_data_in;

   logic [SB-1:0]            env_new;
   logic [SB-1:0]            depth_sat;
   logic [EXC_BITS-1:0]      excess_full;
   logic [SB-1:0]            excess;
   logic [sdg_pkg::COEFF_BITS-1:0] coeff;

   // env*c + peak*(2^C - c) equals peak*2^C + c*(env - peak), so the new
   // envelope is the peak plus the floored, shifted product.
   assign env_new   = work_ff.peak + prod_ff[sdg_pkg::COEFF_BITS +: SB];
   assign depth_sat = (cfg.depth_level > sdg_pkg::ONE_Q) ? sdg_pkg::ONE_Q : cfg.depth_level;
   assign excess_full = prod_ff[PB-1:sdg_pkg::RECIP_FRAC];
   assign excess    = (excess_full > EXC_BITS'(sdg_pkg::ONE_Q)) ?
                      sdg_pkg::ONE_Q : excess_full[SB-1:0];
   assign coeff     = (q_head.peak > env_ff) ? cfg.attack_coeff : cfg.release_coeff;

   assign prod_in   = a_ff * b_ff;

   always_comb begin
      state_in     = state_ff;
      work_in      = work_ff;
      env_in       = env_ff;
      gain_in      = gain_ff;
      above_in     = above_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      left_in      = left_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_pop;
      rsp_data_in  = rsp_data_ff;
      q_pop        = 1'b0;

      case (state_ff)
         sdg_pkg::ST_IDLE: begin
            if (!q_empty) begin
               q_pop    = 1'b1;
               work_in  = q_head;
               a_in     = $signed({1'b0, env_ff}) - $signed({1'b0, q_head.peak});
               b_in     = $signed(MB'(coeff));
               state_in = sdg_pkg::ST_ENV_MUL;
            end
         end
         sdg_pkg::ST_ENV_MUL: begin
            state_in = sdg_pkg::ST_ENV_UPD;
         end
         sdg_pkg::ST_ENV_UPD: begin
            env_in   = env_new;
            above_in = (env_new > cfg.threshold_level);
            a_in     = $signed({1'b0, env_new - cfg.threshold_level});
            b_in     = $signed({1'b0, cfg.range_recip});
            state_in = sdg_pkg::ST_EXC_MUL;
         end
         sdg_pkg::ST_EXC_MUL: begin
            state_in = sdg_pkg::ST_EXC_SET;
         end
         sdg_pkg::ST_EXC_SET: begin
            a_in     = $signed({1'b0, excess});
            b_in     = $signed({1'b0, sdg_pkg::ONE_Q - depth_sat});
            state_in = sdg_pkg::ST_GAIN_MUL;
         end
         sdg_pkg::ST_GAIN_MUL: begin
            state_in = sdg_pkg::ST_GAIN_SET;
         end
         sdg_pkg::ST_GAIN_SET: begin
            if (above_ff) begin
               gain_in = sdg_pkg::ONE_Q - prod_ff[SB-1 +: SB];
               b_in    = $signed({1'b0, sdg_pkg::ONE_Q - prod_ff[SB-1 +: SB]});
            end else begin
               gain_in = sdg_pkg::ONE_Q;
               b_in    = $signed({1'b0, sdg_pkg::ONE_Q});
            end
            a_in     = $signed({work_ff.main_left[SB-1], work_ff.main_left});
            state_in = sdg_pkg::ST_RIGHT_SET;
         end
         sdg_pkg::ST_RIGHT_SET: begin
            a_in     = $signed({work_ff.main_right[SB-1], work_ff.main_right});
            state_in = sdg_pkg::ST_LEFT_OUT;
         end
         sdg_pkg::ST_LEFT_OUT: begin
            left_in  = $signed(prod_ff[SB-1 +: SB]);
            state_in = sdg_pkg::ST_RIGHT_OUT;
         end
         sdg_pkg::ST_RIGHT_OUT: begin
            // The right product stays on the multiplier while the result
            // register is still held by the receiver.
            if (!rsp_valid_ff || rsp_pop) begin
               rsp_valid_in                = 1'b1;
               rsp_data_in.out_left        = left_ff;
               rsp_data_in.out_right       = $signed(prod_ff[SB-1 +: SB]);
               rsp_data_in.applied_gain    = gain_ff;
               rsp_data_in.envelope_level  = env_ff;
               state_in                    = sdg_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = sdg_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sdg_pkg::ST_IDLE;
         env_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         env_ff       <= env_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff     <= work_in;
      gain_ff     <= gain_in;
      above_ff    <= above_in;
      a_ff        <= a_in;
      b_ff        <= b_in;
      prod_ff     <= prod_in;
      left_ff     <= left_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_empty = !rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assert property (@(posedge clock) disable iff (reset)
      env_ff <= sdg_pkg::ONE_Q)
      else $error("envelope rose above full scale");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == sdg_pkg::ST_LEFT_OUT) |-> (gain_ff <= sdg_pkg::ONE_Q))
      else $error("gain above unity reached the output multiply");

   assert property (@(posedge clock) disable iff (reset)
      q_pop |-> (state_ff == sdg_pkg::ST_IDLE && !q_empty))
      else $error("frame taken from the queue outside of idle");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == sdg_pkg::ST_RIGHT_OUT && state_in == sdg_pkg::ST_IDLE)
      |-> (!rsp_valid_ff || rsp_pop))
      else $error("result register overwritten before its beat was taken");

endmodule

`default_nettype wire

@@ hw/rtl/sidechain_ducking_gain.sv @@
// ============================================================================
// sidechain_ducking_gain
// Sidechain ducking gain stage with a peak envelope follower.
// ============================================================================
// Usage:
//   Input frames enter through req_push/req_full: a beat carries two
//   sidechain and two main samples. Results leave through rsp_pop/rsp_empty:
//   a beat carries both ducked main samples, the gain and the envelope.
//   The front reduces the sidechain to a peak and places the frame in a
//   two-entry queue. The back runs the envelope, excess, gain and both
//   output products through one shared 25x25 multiplier, so a frame holds
//   the back from the pop that takes it off the queue until its result is
//   written; the back takes no new frame from the queue before then.
//   While the receiver holds a result, the back finishes the next frame up
//   to its last step and waits there; the queue keeps taking input beats
//   until it is full, and then req_full stays high.
//   Reset (synchronous) empties the queue and the result register, clears
//   the envelope and loads the default register values. Registers are
//   written through the csr_ port at byte addresses four apart.
// ============================================================================
`default_nettype none

module sidechain_ducking_gain (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_push,
   output logic                                      req_full,
   input  wire sdg_pkg::req_type                     req_data,
   output logic                                      rsp_empty,
   input  wire logic                                 rsp_pop,
   output sdg_pkg::rsp_type                          rsp_data,
   input  wire logic                                 csr_psel,
   input  wire logic                                 csr_penable,
   input  wire logic                                 csr_pwrite,
   input  wire logic [sdg_pkg::CSR_ADDR_BITS-1:0]    csr_paddr,
   input  wire logic [sdg_pkg::CSR_DATA_BITS-1:0]    csr_pwdata,
   output logic [sdg_pkg::CSR_DATA_BITS-1:0]         csr_prdata,
   output logic                                      csr_pready
);

   sdg_pkg::cfg_type                   cfg_ff, cfg_in;
   logic [sdg_pkg::REG_IDX_BITS-1:0]   csr_index;
   logic                               csr_write;

   logic                               q_push;
   logic                               q_pop;
   logic                               q_full;
   logic                               q_empty;
   sdg_pkg::work_type                  q_push_data;
   sdg_pkg::work_type                  q_head;

   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[sdg_pkg::CSR_ADDR_BITS-1:2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            sdg_pkg::REG_ATTACK: begin
               cfg_in.attack_coeff = csr_pwdata[sdg_pkg::COEFF_BITS-1:0];
            end
            sdg_pkg::REG_RELEASE: begin
               cfg_in.release_coeff = csr_pwdata[sdg_pkg::COEFF_BITS-1:0];
            end
            sdg_pkg::REG_THRESHOLD: begin
               cfg_in.threshold_level = csr_pwdata[sdg_pkg::SAMPLE_BITS-1:0];
            end
            sdg_pkg::REG_DEPTH: begin
               cfg_in.depth_level = csr_pwdata[sdg_pkg::SAMPLE_BITS-1:0];
            end
            sdg_pkg::REG_RECIP: begin
               cfg_in.range_recip = csr_pwdata[sdg_pkg::RECIP_BITS-1:0];
            end
            sdg_pkg::REG_SIDECHAIN: begin
               cfg_in.sidechain_on = csr_pwdata[0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         sdg_pkg::REG_ATTACK:    csr_prdata = sdg_pkg::CSR_DATA_BITS'(cfg_ff.attack_coeff);
         sdg_pkg::REG_RELEASE:   csr_prdata = sdg_pkg::CSR_DATA_BITS'(cfg_ff.release_coeff);
         sdg_pkg::REG_THRESHOLD: csr_prdata = sdg_pkg::CSR_DATA_BITS'(cfg_ff.threshold_level);
         sdg_pkg::REG_DEPTH:     csr_prdata = sdg_pkg::CSR_DATA_BITS'(cfg_ff.depth_level);
         sdg_pkg::REG_RECIP:     csr_prdata = sdg_pkg::CSR_DATA_BITS'(cfg_ff.range_recip);
         sdg_pkg::REG_SIDECHAIN: csr_prdata = sdg_pkg::CSR_DATA_BITS'(cfg_ff.sidechain_on);
         default:                csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.attack_coeff    <= sdg_pkg::RESET_ATTACK;
         cfg_ff.release_coeff   <= sdg_pkg::RESET_RELEASE;
         cfg_ff.threshold_level <= sdg_pkg::RESET_THRESHOLD;
         cfg_ff.depth_level     <= sdg_pkg::RESET_DEPTH;
         cfg_ff.range_recip     <= sdg_pkg::RESET_RECIP;
         cfg_ff.sidechain_on    <= sdg_pkg::RESET_SIDECHAIN;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   sdg_front u_front (
      .req_push     (req_push),
      .req_full     (req_full),
      .req_data     (req_data),
      .sidechain_on (cfg_ff.sidechain_on),
      .q_full       (q_full),
      .q_push       (q_push),
      .q_data       (q_push_data)
   );

   sdg_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .pop       (q_pop),
      .full      (q_full),
      .empty     (q_empty),
      .head      (q_head)
   );

   sdg_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_empty   (q_empty),
      .q_head    (q_head),
      .q_pop     (q_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

@@ verif/sidechain_ducking_gain_tb.sv @@
// ============================================================================
// sidechain_ducking_gain_tb
// Self-checking bench for the sidechain ducking gain stage. Stereo frames go
// in through the push/full queue port and ducked frames come back through
// the pop/empty port. A scoreboard class predicts each ducked frame from its
// own envelope follower and register copy. Register settings change between
// phases over the APB port, and both sides idle and stall at random.
// ============================================================================

module sidechain_ducking_gain_tb;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned ONE_LEVEL      = sdg_pkg::ONE_Q;
   localparam int unsigned CYCLE_LIMIT    = 500000;
   localparam int unsigned SETTLE_CYCLES  = 16;
   localparam int          RANDOM_PHASES  = 12;
   localparam int          PHASE_FRAMES   = 96;

   // Register slots past the last defined register; writes there are dropped.
   localparam logic [sdg_pkg::REG_IDX_BITS-1:0] REG_SPARE_A = 3'd6;
   localparam logic [sdg_pkg::REG_IDX_BITS-1:0] REG_SPARE_B = 3'd7;

   class ducking_scoreboard;
      logic [sdg_pkg::COEFF_BITS-1:0]  attack_c;
      logic [sdg_pkg::COEFF_BITS-1:0]  release_c;
      logic [sdg_pkg::SAMPLE_BITS-1:0] threshold;
      logic [sdg_pkg::SAMPLE_BITS-1:0] depth;
      logic [sdg_pkg::RECIP_BITS-1:0]  recip;
      logic                            sc_on;
      logic [sdg_pkg::SAMPLE_BITS-1:0] envelope;
      sdg_pkg::rsp_type                ducked_frames[$];
      int                              failures;

      function new();
         attack_c  = sdg_pkg::RESET_ATTACK;
         release_c = sdg_pkg::RESET_RELEASE;
         threshold = sdg_pkg::RESET_THRESHOLD;
         depth     = sdg_pkg::RESET_DEPTH;
         recip     = sdg_pkg::RESET_RECIP;
         sc_on     = sdg_pkg::RESET_SIDECHAIN;
         envelope  = '0;
         failures  = 0;
      endfunction

      function void write_register(logic [sdg_pkg::REG_IDX_BITS-1:0] idx,
                                   logic [31:0] value);
         case (idx)
            sdg_pkg::REG_ATTACK:    attack_c  = value[sdg_pkg::COEFF_BITS-1:0];
            sdg_pkg::REG_RELEASE:   release_c = value[sdg_pkg::COEFF_BITS-1:0];
            sdg_pkg::REG_THRESHOLD: threshold = value[sdg_pkg::SAMPLE_BITS-1:0];
            sdg_pkg::REG_DEPTH:     depth     = value[sdg_pkg::SAMPLE_BITS-1:0];
            sdg_pkg::REG_RECIP:     recip     = value[sdg_pkg::RECIP_BITS-1:0];
            sdg_pkg::REG_SIDECHAIN: sc_on     = value[0];
            default: ;
         endcase
      endfunction

      function int pending();
         return ducked_frames.size();
      endfunction

      // Envelope update, gain and both output products for one frame.
      function void note_frame(sdg_pkg::req_type f);
         longint          sl, sr, pl, pr;
         longint unsigned ml, mr, peak, c, env, excess, dep, gain, one;
         sdg_pkg::rsp_type r;
         one = 64'(ONE_LEVEL);
         sl = longint'($signed(f.side_left));
         sr = longint'($signed(f.side_right));
         ml = (sl < 0) ? longint'(-sl) : longint'(sl);
         mr = (sr < 0) ? longint'(-sr) : longint'(sr);
         peak = 0;
         if (sc_on) begin
            peak = (ml > mr) ? ml : mr;
         end
         c = (peak > 64'(envelope)) ? 64'(attack_c) : 64'(release_c);
         env = (c * 64'(envelope) + (64'd65536 - c) * peak) >> sdg_pkg::COEFF_BITS;
         envelope = env[sdg_pkg::SAMPLE_BITS-1:0];
         gain = one;
         if (env > 64'(threshold)) begin
            excess = ((env - 64'(threshold)) * 64'(recip)) >> sdg_pkg::RECIP_FRAC;
            if (excess > one) begin
               excess = one;
            end
            dep = (64'(depth) > one) ? one : 64'(depth);
            gain = one - ((excess * (one - dep)) >> (sdg_pkg::SAMPLE_BITS - 1));
         end
         // Arithmetic shift floors toward minus infinity, as the block does.
         pl = longint'($signed(f.main_left)) * longint'(gain);
         pr = longint'($signed(f.main_right)) * longint'(gain);
         pl = pl >>> (sdg_pkg::SAMPLE_BITS - 1);
         pr = pr >>> (sdg_pkg::SAMPLE_BITS - 1);
         r.out_left       = pl[sdg_pkg::SAMPLE_BITS-1:0];
         r.out_right      = pr[sdg_pkg::SAMPLE_BITS-1:0];
         r.applied_gain   = gain[sdg_pkg::SAMPLE_BITS-1:0];
         r.envelope_level = envelope;
         ducked_frames = {ducked_frames, r};
      endfunction

      function void compare(string field, logic [sdg_pkg::SAMPLE_BITS-1:0] want,
                            logic [sdg_pkg::SAMPLE_BITS-1:0] got);
         if (got !== want) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
            failures++;
         end
      endfunction

      function void check_result(sdg_pkg::rsp_type got);
         sdg_pkg::rsp_type want;
         if (ducked_frames.size() == 0) begin
            $display("%0t: result with nothing expected, expected none, actual %h",
                     $time, got);
            failures++;
            return;
         end
         want = ducked_frames.pop_front();
         compare("out_left", want.out_left, got.out_left);
         compare("out_right", want.out_right, got.out_right);
         compare("applied_gain", want.applied_gain, got.applied_gain);
         compare("envelope_level", want.envelope_level, got.envelope_level);
      endfunction
   endclass

   logic                               clock;
   logic                               reset       = 1'b1;
   logic                               req_push    = 1'b0;
   logic                               req_full;
   sdg_pkg::req_type                   req_data    = '0;
   logic                               rsp_empty;
   logic                               rsp_pop     = 1'b0;
   sdg_pkg::rsp_type                   rsp_data;
   logic                               csr_psel    = 1'b0;
   logic                               csr_penable = 1'b0;
   logic                               csr_pwrite  = 1'b0;
   logic [sdg_pkg::CSR_ADDR_BITS-1:0]  csr_paddr   = '0;
   logic [sdg_pkg::CSR_DATA_BITS-1:0]  csr_pwdata  = '0;
   logic [sdg_pkg::CSR_DATA_BITS-1:0]  csr_prdata;
   logic                               csr_pready;

   ducking_scoreboard sb = new();

   int unsigned send_idle_pct  = 0;
   int unsigned recv_stall_pct = 0;
   int unsigned hold_request   = 0;
   int unsigned hold_left      = 0;
   int unsigned cycle_count    = 0;

   sidechain_ducking_gain dut (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_full    (req_full),
      .req_data    (req_data),
      .rsp_empty   (rsp_empty),
      .rsp_pop     (rsp_pop),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // Receiver: random stalls, plus a long hold-off when one is requested.
   always @(posedge clock) begin
      if (hold_request != 0) begin
         hold_left = hold_request;
         hold_request = 0;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_pop <= 1'b0;
      end else begin
         rsp_pop <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Beats are taken on the values seen just before the edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_push && !req_full) begin
            sb.note_frame(req_data);
         end
         if (rsp_pop && !rsp_empty) begin
            sb.check_result(rsp_data);
         end
      end
   end

   task automatic push_frame(input sdg_pkg::req_type f);
      while ($urandom_range(99) < send_idle_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push <= 1'b1;
      req_data <= f;
      do @(posedge clock); while (req_full !== 1'b0);
   endtask

   // Stop sending and wait until every predicted frame has come back.
   task automatic drain_and_settle();
      req_push <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [sdg_pkg::REG_IDX_BITS-1:0] idx,
                            input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= sdg_pkg::CSR_ADDR_BITS'({idx, 2'b00});
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      sb.write_register(idx, value);
   endtask

   task automatic csr_done();
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   function automatic sdg_pkg::req_type frame_of(int sl, int sr, int ml, int mr);
      sdg_pkg::req_type f;
      f.side_left  = sdg_pkg::SAMPLE_BITS'(sl);
      f.side_right = sdg_pkg::SAMPLE_BITS'(sr);
      f.main_left  = sdg_pkg::SAMPLE_BITS'(ml);
      f.main_right = sdg_pkg::SAMPLE_BITS'(mr);
      return f;
   endfunction

   function automatic logic [31:0] random_coeff();
      case ($urandom_range(5))
         0: return 32'd0;
         1: return 32'd65535;
         2: return $urandom_range(16383);
         3: return $urandom_range(65535, 32768);
         4: return $urandom();
         default: return $urandom_range(65535);
      endcase
   endfunction

   function automatic logic [31:0] random_threshold();
      case ($urandom_range(6))
         0: return 32'd0;
         1: return ONE_LEVEL;
         2: return 32'hFF_FFFF;
         3: return $urandom();
         4: return $urandom_range(ONE_LEVEL);
         default: return $urandom_range(ONE_LEVEL / 4);
      endcase
   endfunction

   function automatic logic [31:0] random_depth();
      case ($urandom_range(5))
         0: return 32'd0;
         1: return ONE_LEVEL;
         2: return $urandom_range(32'hFF_FFFF, ONE_LEVEL + 1);
         3: return $urandom();
         default: return $urandom_range(ONE_LEVEL);
      endcase
   endfunction

   function automatic logic [31:0] random_recip();
      case ($urandom_range(6))
         0: return 32'd65536;
         1: return 32'hFF_FFFF;
         2: return $urandom_range(65535);
         3: return $urandom();
         4: return $urandom_range(32'hFF_FFFF, 65536);
         default: return $urandom_range(65536 * 16, 65536);
      endcase
   endfunction

   task automatic program_random_setting();
      write_reg(sdg_pkg::REG_ATTACK, random_coeff());
      write_reg(sdg_pkg::REG_RELEASE, random_coeff());
      write_reg(sdg_pkg::REG_THRESHOLD, random_threshold());
      write_reg(sdg_pkg::REG_DEPTH, random_depth());
      write_reg(sdg_pkg::REG_RECIP, random_recip());
      case ($urandom_range(5))
         0: write_reg(sdg_pkg::REG_SIDECHAIN, 32'd0);
         1: write_reg(sdg_pkg::REG_SIDECHAIN, $urandom());
         default: write_reg(sdg_pkg::REG_SIDECHAIN, 32'd1);
      endcase
      if ($urandom_range(3) == 0) begin
         write_reg($urandom_range(1) ? REG_SPARE_A : REG_SPARE_B, $urandom());
      end
      csr_done();
   endtask

   function automatic logic [sdg_pkg::SAMPLE_BITS-1:0] pick_sample(int unsigned kind);
      logic [sdg_pkg::SAMPLE_BITS-1:0] mag;
      case (kind)
         0: return sdg_pkg::SAMPLE_BITS'($urandom());
         1: begin
            case ($urandom_range(4))
               0: return sdg_pkg::ONE_Q;
               1: return sdg_pkg::ONE_Q - 1'b1;
               2: return '0;
               3: return '1;
               default: return sdg_pkg::SAMPLE_BITS'(1);
            endcase
         end
         2: begin
            mag = sdg_pkg::SAMPLE_BITS'($urandom_range(4095));
            return $urandom_range(1) ? -mag : mag;
         end
         default: begin
            mag = sdg_pkg::SAMPLE_BITS'($urandom_range(ONE_LEVEL - 1, ONE_LEVEL / 2));
            return $urandom_range(1) ? -mag : mag;
         end
      endcase
   endfunction

   // Loud stretches push the envelope over the threshold, quiet ones let it fall.
   function automatic int unsigned side_kind(bit loud);
      int unsigned k;
      if (loud) begin
         k = $urandom_range(5);
         return (k <= 2) ? 3 : k - 3;
      end
      k = $urandom_range(3);
      return (k <= 1) ? 2 : k - 2;
   endfunction

   function automatic sdg_pkg::req_type random_frame(bit loud);
      sdg_pkg::req_type f;
      f.side_left  = pick_sample(side_kind(loud));
      f.side_right = pick_sample(side_kind(loud));
      f.main_left  = pick_sample(($urandom_range(7) == 0) ? 1 : 0);
      f.main_right = pick_sample(($urandom_range(7) == 0) ? 1 : 0);
      return f;
   endfunction

   initial begin
      bit          loud;
      int unsigned run_left;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Power-on register values, full-scale and alternating bit patterns.
      push_frame(frame_of(0, 0, 0, 0));
      push_frame(frame_of(-8388608, 0, 8388607, -8388608));
      push_frame(frame_of(8388607, -8388608, -8388608, 8388607));
      push_frame(frame_of(1, -1, -1, 1));
      push_frame(frame_of(24'h555555, 24'hAAAAAA, 24'h555555, 24'hAAAAAA));
      push_frame(frame_of(24'hAAAAAA, 24'h555555, 24'hAAAAAA, 24'h555555));
      drain_and_settle();

      // Zero coefficients make the envelope jump to the peak; full ducking.
      write_reg(sdg_pkg::REG_ATTACK, 32'd0);
      write_reg(sdg_pkg::REG_RELEASE, 32'd0);
      write_reg(sdg_pkg::REG_THRESHOLD, 32'd0);
      write_reg(sdg_pkg::REG_DEPTH, 32'd0);
      write_reg(sdg_pkg::REG_RECIP, 32'hFF_FFFF);
      write_reg(sdg_pkg::REG_SIDECHAIN, 32'd1);
      csr_done();
      push_frame(frame_of(-8388608, 0, 8388607, -8388608));
      push_frame(frame_of(100, -200, 8388607, -8388608));
      push_frame(frame_of(0, 0, -1, 8388607));
      push_frame(frame_of(1, 0, -1, -8388608));
      push_frame(frame_of(-1, -1, -1, -1));
      push_frame(frame_of(8388607, 8388607, 12345, -12345));
      drain_and_settle();

      // Coefficients wider than their field, sidechain off, writes past the map.
      write_reg(sdg_pkg::REG_ATTACK, 32'h0001_FFFF);
      write_reg(sdg_pkg::REG_RELEASE, 32'hABCD_0000);
      write_reg(sdg_pkg::REG_THRESHOLD, 32'hFFFF_FFFF);
      write_reg(sdg_pkg::REG_DEPTH, 32'hFFFF_FFFF);
      write_reg(sdg_pkg::REG_RECIP, 32'd0);
      write_reg(sdg_pkg::REG_SIDECHAIN, 32'd2);
      write_reg(REG_SPARE_A, 32'hFFFF_FFFF);
      write_reg(REG_SPARE_B, 32'h1234_5678);
      csr_done();
      push_frame(frame_of(-8388608, 8388607, 8388607, -8388608));
      push_frame(frame_of(8388607, -8388608, -8388608, 8388607));
      drain_and_settle();

      // Threshold at full scale never ducks; nor does full-scale depth, here with a tiny reciprocal.
      write_reg(sdg_pkg::REG_ATTACK, 32'd0);
      write_reg(sdg_pkg::REG_THRESHOLD, ONE_LEVEL);
      write_reg(sdg_pkg::REG_SIDECHAIN, 32'd1);
      csr_done();
      push_frame(frame_of(-8388608, 0, 8388607, -8388608));
      push_frame(frame_of(0, -8388608, -8388608, 8388607));
      drain_and_settle();
      write_reg(sdg_pkg::REG_THRESHOLD, ONE_LEVEL - 1);
      write_reg(sdg_pkg::REG_RECIP, 32'd1);
      write_reg(sdg_pkg::REG_DEPTH, ONE_LEVEL);
      csr_done();
      push_frame(frame_of(-8388608, 0, 8388607, -8388608));
      push_frame(frame_of(-8388608, -8388608, -8388608, -1));
      push_frame(frame_of(8388607, 0, 4194304, -4194304));
      drain_and_settle();

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         case (p % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 74; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 74; end
            default: begin send_idle_pct = 25; recv_stall_pct = 25; end
         endcase
         program_random_setting();
         // Holding the receiver off lets the queue fill until req_full rises.
         if (p == 0) begin
            hold_request = 250;
         end
         loud = 1'b0;
         run_left = 0;
         for (int n = 0; n < PHASE_FRAMES; n++) begin
            if (run_left == 0) begin
               loud = !loud;
               run_left = $urandom_range(40, 8);
            end
            run_left--;
            push_frame(random_frame(loud));
         end
         drain_and_settle();
      end

      if (sb.failures == 0 && sb.pending() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
